### src/cnbc_pkg.sv
// Shared constants, types and register indexes of the coefficient norm bound checker.
`timescale 1ns / 1ps

package cnbc_pkg;

   localparam int COEFF_COUNT = 256;
   localparam int BYTE_TOTAL  = COEFF_COUNT * 4;
   localparam int SEEN_W      = $clog2(BYTE_TOTAL + 1);

   localparam int BYTE_W      = 8;
   localparam int PARTIAL_W   = 24;
   localparam int WORD_W      = 32;
   localparam int SUM_W       = 64;
   localparam int LINF_W      = 31;
   localparam int TALLY_W     = $clog2(COEFF_COUNT + 1);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_L2_LIMIT      = 2'd0,
      CSR_LINF_LIMIT    = 2'd1,
      CSR_DENSITY_LIMIT = 2'd2
   } csr_index_type;

   // One entry handed from byte assembly to the statistics pipeline.
   typedef struct packed {
      logic              coeff_valid;
      logic [WORD_W-1:0] magnitude;
      logic              nonzero;
      logic              last;
      logic              short_sol;
   } coeff_token_type;

   // Totals of one finished solution.
   typedef struct packed {
      logic [SUM_W-1:0]   square_sum;
      logic [WORD_W-1:0]  max_magnitude;
      logic [TALLY_W-1:0] nonzero_count;
      logic               short_sol;
   } stats_type;

endpackage

### src/cnbc_channel_ifs.sv
// Valid/ready channel interfaces for the request bytes and the verdict results.
`timescale 1ns / 1ps

interface cnbc_req_if;
   logic                       valid;
   logic                       ready;
   logic [cnbc_pkg::BYTE_W-1:0] data_byte;
   logic                       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cnbc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         accepted;
   logic                         too_short;
   logic                         l2_over;
   logic                         linf_over;
   logic                         density_over;
   logic [cnbc_pkg::SUM_W-1:0]   square_sum;
   logic [cnbc_pkg::WORD_W-1:0]  max_magnitude;
   logic [cnbc_pkg::TALLY_W-1:0] nonzero_count;

   modport source (output valid, output accepted, output too_short, output l2_over,
                   output linf_over, output density_over, output square_sum,
                   output max_magnitude, output nonzero_count, input ready);
   modport sink   (input valid, input accepted, input too_short, input l2_over,
                   input linf_over, input density_over, input square_sum,
                   input max_magnitude, input nonzero_count, output ready);
endinterface

### src/cnbc_coeff_stats.sv
// Squaring and accumulation pipeline that turns coefficient magnitudes into solution totals.
`timescale 1ns / 1ps

module cnbc_coeff_stats (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  cnbc_pkg::coeff_token_type in_token,
   output logic                      out_valid,
   input  logic                      out_ready,
   output cnbc_pkg::stats_type       out_stats
);

   logic                      b_valid_ff;
   cnbc_pkg::coeff_token_type b_token_ff;

   logic                           c_valid_ff;
   logic                           c_coeff_valid_ff;
   logic                           c_nonzero_ff;
   logic                           c_last_ff;
   logic                           c_short_ff;
   logic [cnbc_pkg::WORD_W-1:0]    c_mag_ff;
   logic [cnbc_pkg::SUM_W-1:0]     c_square_ff;

   logic [cnbc_pkg::SUM_W-1:0]     sum_ff;
   logic [cnbc_pkg::WORD_W-1:0]    peak_ff;
   logic [cnbc_pkg::TALLY_W-1:0]   tally_ff;
   logic [cnbc_pkg::SUM_W-1:0]     sum_in;
   logic [cnbc_pkg::WORD_W-1:0]    peak_in;
   logic [cnbc_pkg::TALLY_W-1:0]   tally_in;
   logic [cnbc_pkg::SUM_W:0]       sum_wide;

   logic                d_valid_ff;
   cnbc_pkg::stats_type d_stats_ff;

   logic d_free;
   logic c_adv;
   logic c_free;
   logic b_adv;

   assign d_free   = !d_valid_ff || out_ready;
   assign c_adv    = c_valid_ff && (!c_last_ff || d_free);
   assign c_free   = !c_valid_ff || c_adv;
   assign b_adv    = b_valid_ff && c_free;
   assign in_ready = !b_valid_ff || b_adv;

   assign out_valid = d_valid_ff;
   assign out_stats = d_stats_ff;

   always_comb begin
      sum_wide = {1'b0, sum_ff} + {1'b0, c_square_ff};
      sum_in   = sum_ff;
      peak_in  = peak_ff;
      tally_in = tally_ff;
      if (c_coeff_valid_ff) begin
         sum_in = sum_wide[cnbc_pkg::SUM_W] ? cnbc_pkg::SUM_MAX
                                            : sum_wide[cnbc_pkg::SUM_W-1:0];
         if (c_mag_ff > peak_ff) begin
            peak_in = c_mag_ff;
         end
         if (c_nonzero_ff) begin
            tally_in = tally_ff + cnbc_pkg::TALLY_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (in_ready) begin
         b_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         b_token_ff <= in_token;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (c_free) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         c_coeff_valid_ff <= b_token_ff.coeff_valid;
         c_nonzero_ff     <= b_token_ff.nonzero;
         c_last_ff        <= b_token_ff.last;
         c_short_ff       <= b_token_ff.short_sol;
         c_mag_ff         <= b_token_ff.magnitude;
         c_square_ff      <= b_token_ff.magnitude * b_token_ff.magnitude;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         peak_ff  <= '0;
         tally_ff <= '0;
      end else if (c_adv) begin
         if (c_last_ff) begin
            sum_ff   <= '0;
            peak_ff  <= '0;
            tally_ff <= '0;
         end else begin
            sum_ff   <= sum_in;
            peak_ff  <= peak_in;
            tally_ff <= tally_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (c_adv && c_last_ff) begin
         d_valid_ff <= 1'b1;
      end else if (out_ready) begin
         d_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (c_adv && c_last_ff) begin
         d_stats_ff.square_sum    <= sum_in;
         d_stats_ff.max_magnitude <= peak_in;
         d_stats_ff.nonzero_count <= tally_in;
         d_stats_ff.short_sol     <= c_short_ff;
      end
   end

endmodule

### src/coefficient_norm_bound_checker.sv
// Top level of the coefficient norm bound checker: byte assembly, limits and verdict register.
//
//   channel   direction  handshake        payload
//   req_chan  in         valid / ready    data_byte, last_byte
//   rsp_chan  out        valid / ready    accepted, flags, square_sum, max_magnitude,
//                                         nonzero_count
//   csr_*     in         csr_write_en     csr_index, csr_wdata
//
// One byte is taken per clock while req_chan.ready is high, as the squaring multiplier is
// pipelined. A verdict leaves four register stages after its final byte.
// Reset is synchronous and clears all totals, limits and valid bits.
// A stalled result holds its register while the pipeline stages ahead keep filling;
// the input stalls only when every stage holds a transfer.
`timescale 1ns / 1ps

module coefficient_norm_bound_checker (
   input  logic                               clock,
   input  logic                               reset,
   cnbc_req_if.sink                           req_chan,
   cnbc_rsp_if.source                         rsp_chan,
   input  logic                               csr_write_en,
   input  logic [cnbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cnbc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [cnbc_pkg::SUM_W-1:0]     l2_limit_ff;
   logic [cnbc_pkg::LINF_W-1:0]    linf_limit_ff;
   logic [cnbc_pkg::TALLY_W-1:0]   density_limit_ff;

   logic [cnbc_pkg::SEEN_W-1:0]    seen_ff;
   logic [cnbc_pkg::SEEN_W-1:0]    seen_in;
   logic [cnbc_pkg::PARTIAL_W-1:0] partial_ff;
   logic [cnbc_pkg::PARTIAL_W-1:0] partial_in;
   logic [cnbc_pkg::WORD_W-1:0]    word;
   logic                           in_range;
   logic                           req_transfer;

   cnbc_pkg::coeff_token_type token;
   logic                      token_valid;
   logic                      stats_valid;
   logic                      stats_ready;
   cnbc_pkg::stats_type       stats;

   logic                           rsp_valid_ff;
   logic                           accepted_ff;
   logic                           too_short_ff;
   logic                           l2_over_ff;
   logic                           linf_over_ff;
   logic                           density_over_ff;
   logic [cnbc_pkg::SUM_W-1:0]     square_sum_ff;
   logic [cnbc_pkg::WORD_W-1:0]    max_magnitude_ff;
   logic [cnbc_pkg::TALLY_W-1:0]   nonzero_count_ff;
   logic                           l2_over_in;
   logic                           linf_over_in;
   logic                           density_over_in;

   assign in_range     = seen_ff < cnbc_pkg::SEEN_W'(cnbc_pkg::BYTE_TOTAL);
   assign req_transfer = req_chan.valid && req_chan.ready;

   always_comb begin
      seen_in           = seen_ff;
      partial_in        = partial_ff;
      word              = {req_chan.data_byte, partial_ff};
      token.coeff_valid = 1'b0;
      if (in_range) begin
         case (seen_ff[1:0])
            2'd0:    partial_in[7:0]   = req_chan.data_byte;
            2'd1:    partial_in[15:8]  = req_chan.data_byte;
            2'd2:    partial_in[23:16] = req_chan.data_byte;
            default: begin
               token.coeff_valid = 1'b1;
               partial_in        = '0;
            end
         endcase
         seen_in = seen_ff + cnbc_pkg::SEEN_W'(1);
      end
      token.magnitude = word[cnbc_pkg::WORD_W-1] ? (~word + cnbc_pkg::WORD_W'(1)) : word;
      token.nonzero   = word != '0;
      token.last      = req_chan.last_byte;
      token.short_sol = seen_in < cnbc_pkg::SEEN_W'(cnbc_pkg::BYTE_TOTAL);
   end

   assign token_valid = req_chan.valid && (token.coeff_valid || req_chan.last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         partial_ff <= '0;
      end else if (req_transfer) begin
         if (req_chan.last_byte) begin
            seen_ff    <= '0;
            partial_ff <= '0;
         end else begin
            seen_ff    <= seen_in;
            partial_ff <= partial_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l2_limit_ff      <= '0;
         linf_limit_ff    <= '0;
         density_limit_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            cnbc_pkg::CSR_L2_LIMIT:      l2_limit_ff      <= csr_wdata;
            cnbc_pkg::CSR_LINF_LIMIT:    linf_limit_ff    <= csr_wdata[cnbc_pkg::LINF_W-1:0];
            cnbc_pkg::CSR_DENSITY_LIMIT: density_limit_ff <= csr_wdata[cnbc_pkg::TALLY_W-1:0];
            default: ;
         endcase
      end
   end

   cnbc_coeff_stats u_stats (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (token_valid),
      .in_ready  (req_chan.ready),
      .in_token  (token),
      .out_valid (stats_valid),
      .out_ready (stats_ready),
      .out_stats (stats)
   );

   assign stats_ready = !rsp_valid_ff || rsp_chan.ready;

   // A saturated sum counts as over any limit.
   assign l2_over_in      = (stats.square_sum > l2_limit_ff) ||
                            (stats.square_sum == cnbc_pkg::SUM_MAX);
   assign linf_over_in    = stats.max_magnitude > {1'b0, linf_limit_ff};
   assign density_over_in = stats.nonzero_count > density_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stats_ready) begin
         rsp_valid_ff <= stats_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stats_ready && stats_valid) begin
         accepted_ff      <= !stats.short_sol && !l2_over_in && !linf_over_in &&
                             !density_over_in;
         too_short_ff     <= stats.short_sol;
         l2_over_ff       <= l2_over_in;
         linf_over_ff     <= linf_over_in;
         density_over_ff  <= density_over_in;
         square_sum_ff    <= stats.square_sum;
         max_magnitude_ff <= stats.max_magnitude;
         nonzero_count_ff <= stats.nonzero_count;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.accepted      = accepted_ff;
   assign rsp_chan.too_short     = too_short_ff;
   assign rsp_chan.l2_over       = l2_over_ff;
   assign rsp_chan.linf_over     = linf_over_ff;
   assign rsp_chan.density_over  = density_over_ff;
   assign rsp_chan.square_sum    = square_sum_ff;
   assign rsp_chan.max_magnitude = max_magnitude_ff;
   assign rsp_chan.nonzero_count = nonzero_count_ff;

endmodule
